// ----- hdl/gsrde_pkg.sv -----
// Package for the grid series reference delta encoder.
// Holds result kinds, the in-flight item type and the 17-bit zigzag function.
// No dependencies.
`default_nettype none

package gsrde_pkg;

    // Result kinds on the output channel
    localparam logic [2:0] KIND_REF_FIRST = 3'd0;
    localparam logic [2:0] KIND_REF_DELTA = 3'd1;
    localparam logic [2:0] KIND_DIFF      = 3'd2;
    localparam logic [2:0] KIND_VERDICT   = 3'd3;
    localparam logic [2:0] KIND_MINIMUM   = 3'd4;

    // Bit positions in the pending-result mask
    localparam int RES_MAIN    = 0;
    localparam int RES_VERDICT = 1;
    localparam int RES_MIN     = 2;
    localparam int RES_COUNT   = 3;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;

    typedef logic [RES_COUNT-1:0] res_mask_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [9:0]         time_idx;
        logic [2:0]         kind;
        logic [16:0]        code;
        logic signed [15:0] first_value;
        logic               is_const;
        logic signed [15:0] minimum;
    } item_t;

    // Zigzag code of (a - b), difference wrapped to 17 bits
    function automatic logic [16:0] zigzag17(logic signed [15:0] a, logic signed [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return {d[15:0], 1'b0} ^ {17{d[16]}};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/grid_series_reference_delta_encoder_top.sv -----
// A result passes through the P and S1 registers to the output register. Throughput: one item
// per cycle while each item causes one result and the output is not stalled; an item ending a
// series holds the result stage while its verdict drains, the grid's last item also while its
// minimum drains. The output register is the pacing point; the reference memory is read once
// per item not in row 0. Reset clears control, sets the running minimum (to 32767), constancy
// flag and series length (to 1024, clamped); reference memory is not cleared, valid once written.
`default_nettype none

module grid_series_reference_delta_encoder_top
    import gsrde_pkg::*;
#(
    parameter int GRID_ROWS   = 9,
    parameter int GRID_COLS   = 9,
    parameter int MAX_SAMPLES = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // configuration write: series length
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [10:0]        series_length,

    // input item channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] sample,
    input  wire logic [3:0]         grid_row,
    input  wire logic [3:0]         grid_col,
    input  wire logic [9:0]         time_index,

    // result item channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              kind,
    output logic [16:0]             code,
    output logic signed [15:0]      raw_value,
    output logic [3:0]              out_row,
    output logic [3:0]              out_col,
    output logic [9:0]              out_time,
    output logic                    is_constant,
    output logic                    last
);

    // Address width of the reference memory and the compare width for time indexes
    localparam int AW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = (AW > 10) ? AW : 10;
    localparam int RESET_LEN = (MAX_SAMPLES < 1024) ? MAX_SAMPLES : 1024;
    localparam logic [AW-1:0] RESET_LAST = AW'(RESET_LEN - 1);
    localparam logic [AW-1:0] MAX_LAST   = AW'(MAX_SAMPLES - 1);
    localparam logic [3:0]    LAST_ROW   = 4'(GRID_ROWS - 1);
    localparam logic [3:0]    LAST_COL   = 4'(GRID_COLS - 1);

    // ------------------------------------------------------------------
    // Configuration: keep the clamped length as its last time index
    // ------------------------------------------------------------------
    logic [AW-1:0] len_last_reg;
    logic [AW-1:0] len_last_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (series_length < 11'd2)
        begin
            len_last_next = AW'(1);
        end
        else if (32'(series_length) > 32'(MAX_SAMPLES))
        begin
            len_last_next = MAX_LAST;
        end
        else
        begin
            len_last_next = AW'(series_length - 11'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_last_reg <= RESET_LAST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_last_reg <= len_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake between stages
    //   accept -> P (reference read in flight) -> S1 (results drain) -> output register
    // ------------------------------------------------------------------
    logic      p_valid_reg;
    item_t     p_item_reg;
    res_mask_t p_mask_reg;
    res_mask_t s1_mask_reg;
    item_t     s1_item_reg;
    logic      out_valid_reg;

    logic out_ready;
    logic s1_take;
    logic s1_load_ok;
    logic p_advance;
    logic in_accept;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign s1_take    = out_ready && (s1_mask_reg != '0);
    assign s1_load_ok = (s1_mask_reg == '0) || (s1_take && $onehot(s1_mask_reg));
    assign p_advance  = p_valid_reg && s1_load_ok;
    assign in_stall   = p_valid_reg && !s1_load_ok;
    assign in_accept  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Accept stage: range filter, scalar state update, reference access
    // ------------------------------------------------------------------
    logic [CW-1:0] t_cmp;
    logic          in_hit;
    logic          row_is_ref;
    logic          ends;
    logic          grid_end;

    logic signed [15:0] prev_reg;
    logic signed [15:0] first_reg;
    logic               const_reg;
    logic signed [15:0] min_reg;

    logic signed [15:0] prev_next;
    logic signed [15:0] first_next;
    logic               const_next;
    logic signed [15:0] min_next;
    logic signed [15:0] min_seen;

    item_t     acc_item;
    res_mask_t acc_mask;

    assign t_cmp      = CW'(time_index);
    assign in_hit     = (32'(grid_row) < 32'(GRID_ROWS)) && (32'(grid_col) < 32'(GRID_COLS))
                        && (t_cmp <= CW'(len_last_reg));
    assign row_is_ref = (grid_row == 4'd0);
    assign ends       = !row_is_ref && (t_cmp == CW'(len_last_reg));
    assign grid_end   = ends && (grid_row == LAST_ROW) && (grid_col == LAST_COL);

    always_comb
    begin
        min_seen   = (sample < min_reg) ? sample : min_reg;
        prev_next  = sample;
        first_next = first_reg;
        const_next = const_reg;
        min_next   = grid_end ? SAMPLE_MAX : min_seen;

        if (!row_is_ref)
        begin
            if (time_index == 10'd0)
            begin
                first_next = sample;
                const_next = 1'b1;
            end
            else if (sample != prev_reg)
            begin
                const_next = 1'b0;
            end
        end

        acc_item.sample      = sample;
        acc_item.row         = grid_row;
        acc_item.col         = grid_col;
        acc_item.time_idx    = time_index;
        acc_item.first_value = first_next;
        acc_item.is_const    = const_next;
        acc_item.minimum     = min_seen;
        acc_item.code        = '0;
        if (!row_is_ref)
        begin
            acc_item.kind = KIND_DIFF;
        end
        else if (time_index == 10'd0)
        begin
            acc_item.kind = KIND_REF_FIRST;
        end
        else
        begin
            acc_item.kind = KIND_REF_DELTA;
            acc_item.code = zigzag17(sample, prev_reg);
        end

        acc_mask              = '0;
        acc_mask[RES_MAIN]    = 1'b1;
        acc_mask[RES_VERDICT] = ends;
        acc_mask[RES_MIN]     = grid_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            first_reg <= '0;
            const_reg <= 1'b1;
            min_reg   <= SAMPLE_MAX;
        end
        else if (in_accept && in_hit)
        begin
            prev_reg  <= prev_next;
            first_reg <= first_next;
            const_reg <= const_next;
            min_reg   <= min_next;
        end
    end

    // Reference memory: written by row 0, read by every other row into rd_data_reg on acceptance
    logic [15:0]   ref_mem [MAX_SAMPLES];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] ref_addr;

    assign ref_addr = t_cmp[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_accept && in_hit && row_is_ref)
        begin
            ref_mem[ref_addr] <= sample;
        end
        if (in_accept && in_hit && !row_is_ref)
        begin
            rd_data_reg <= ref_mem[ref_addr];
        end
    end

    // P stage: hold the item until the result stage frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            p_valid_reg <= in_hit;
        end
        else if (p_advance)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_hit)
        begin
            p_item_reg <= acc_item;
            p_mask_reg <= acc_mask;
        end
    end

    // ------------------------------------------------------------------
    // S1: finish the difference code, then drain pending results in order
    // ------------------------------------------------------------------
    item_t p_item_done;

    always_comb
    begin
        p_item_done = p_item_reg;
        if (p_item_reg.kind == KIND_DIFF)
        begin
            p_item_done.code = zigzag17(signed'(rd_data_reg), p_item_reg.sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_mask_reg <= '0;
        end
        else if (p_advance)
        begin
            s1_mask_reg <= p_mask_reg;
        end
        else if (s1_take)
        begin
            // drop the result just sent
            s1_mask_reg <= s1_mask_reg & (s1_mask_reg - res_mask_t'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_advance)
        begin
            s1_item_reg <= p_item_done;
        end
    end

    // Select the next pending result
    logic [2:0]         sel_kind;
    logic [16:0]        sel_code;
    logic signed [15:0] sel_raw;
    logic [3:0]         sel_row;
    logic [3:0]         sel_col;
    logic [9:0]         sel_time;
    logic               sel_const;
    logic               sel_last;

    always_comb
    begin
        sel_row   = s1_item_reg.row;
        sel_col   = s1_item_reg.col;
        sel_time  = s1_item_reg.time_idx;
        sel_code  = '0;
        sel_raw   = '0;
        sel_const = 1'b0;
        sel_last  = $onehot(s1_mask_reg);
        if (s1_mask_reg[RES_MAIN])
        begin
            sel_kind = s1_item_reg.kind;
            sel_code = s1_item_reg.code;
            if (s1_item_reg.kind == KIND_REF_FIRST)
            begin
                sel_raw = s1_item_reg.sample;
            end
        end
        else if (s1_mask_reg[RES_VERDICT])
        begin
            sel_kind  = KIND_VERDICT;
            sel_raw   = s1_item_reg.first_value;
            sel_const = s1_item_reg.is_const;
        end
        else
        begin
            sel_kind = KIND_MINIMUM;
            sel_raw  = s1_item_reg.minimum;
            sel_row  = '0;
            sel_col  = '0;
            sel_time = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            kind        <= sel_kind;
            code        <= sel_code;
            raw_value   <= sel_raw;
            out_row     <= sel_row;
            out_col     <= sel_col;
            out_time    <= sel_time;
            is_constant <= sel_const;
            last        <= sel_last;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> p_valid_reg)
        else $error("input stalled with empty read stage");

    a_min_implies_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        s1_mask_reg[RES_MIN] |-> s1_mask_reg[RES_VERDICT] || !s1_mask_reg[RES_MAIN])
        else $error("minimum pending without series verdict");

    a_verdict_not_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_mask_reg[RES_VERDICT] && s1_mask_reg[RES_MAIN]) |-> s1_item_reg.row != 4'd0)
        else $error("verdict pending for reference row");

    a_min_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind == KIND_MINIMUM) |-> (out_row == 4'd0 && out_col == 4'd0 && last))
        else $error("minimum result with cell fields or not last");

    a_take_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take |=> out_valid_reg)
        else $error("result moved but output register empty");

endmodule

`default_nettype wire

// ----- tb/grid_series_reference_delta_encoder_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for grid_series_reference_delta_encoder_top.
// Depends on gsrde_pkg (result kinds, largest sample) and the encoder RTL only.

module grid_series_reference_delta_encoder_top_test;
    import gsrde_pkg::*;

    localparam int NUM_ROWS     = 9;
    localparam int NUM_COLS     = 9;
    localparam int MAX_LEN      = 1024;
    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 12;       // covers the pipeline latency plus multi-result holds
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    // One sample of a grid cell series, as driven on the input channel
    typedef struct packed {
        logic signed [15:0] sample;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [9:0]         tidx;
    } sample_item_t;

    // One encoded result, as seen on the output channel
    typedef struct packed {
        logic [2:0]         kind;
        logic [16:0]        code;
        logic signed [15:0] raw;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [9:0]         tidx;
        logic               cst;
        logic               lst;
    } result_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] series_length = 11'd0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] sample = 16'sd0;
    logic [3:0]         grid_row = 4'd0;
    logic [3:0]         grid_col = 4'd0;
    logic [9:0]         time_index = 10'd0;

    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [2:0]         kind;
    logic [16:0]        code;
    logic signed [15:0] raw_value;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic [9:0]         out_time;
    logic               is_constant;
    logic               last;

    sample_item_t pending_samples[$];
    result_item_t expected_results[$];

    int   error_count = 0;
    int   cycle_count = 0;
    logic in_taken = 1'b0;
    logic steady = 1'b0;        // when set, neither side idles

    // Encoder state as predicted by the testbench
    logic [10:0]        length_reg = 11'd1024;
    logic signed [15:0] ref_series[MAX_LEN];
    logic signed [15:0] prev_sample = 16'sd0;
    logic signed [15:0] series_first = 16'sd0;
    logic               series_const = 1'b1;
    logic signed [15:0] grid_minimum = SAMPLE_MAX;

    // Stimulus bookkeeping: series length seen by the generator and
    // which reference entries have been written since reset
    int gen_len = MAX_LEN;
    bit ref_seen[MAX_LEN];
    int live_items = 0;

    grid_series_reference_delta_encoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .series_length (series_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .grid_row      (grid_row),
        .grid_col      (grid_col),
        .time_index    (time_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .code          (code),
        .raw_value     (raw_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_time      (out_time),
        .is_constant   (is_constant),
        .last          (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Zigzag code of (a - b). Both operands are 16-bit, so the difference
    // already fits a signed 17-bit value and the wrap never bites.
    function automatic logic [16:0] zigzag_of_diff(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        int d;
        int z;
        d = int'(a) - int'(b);
        z = (d >= 0) ? 2 * d : -2 * d - 1;
        return z[16:0];
    endfunction

    function automatic result_item_t make_result(logic [2:0] k, logic [16:0] c,
                                                 logic signed [15:0] r, logic [3:0] row,
                                                 logic [3:0] col, logic [9:0] t,
                                                 logic cst, logic lst);
        result_item_t res;
        res.kind = k;
        res.code = c;
        res.raw  = r;
        res.row  = row;
        res.col  = col;
        res.tidx = t;
        res.cst  = cst;
        res.lst  = lst;
        return res;
    endfunction

    // Append one predicted result at the tail of the expected queue.
    task automatic append_result(result_item_t res);
        expected_results.insert(expected_results.size(), res);
    endtask

    // Advance the predicted state by one accepted sample and queue the
    // results it must cause, in order.
    task automatic encode_sample(sample_item_t it);
        int len;
        bit ends;
        bit grid_end;
        len = (length_reg < 2) ? 2 : ((length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg));
        // Drop items outside the grid or past the end of a series: no state change.
        if (it.row < NUM_ROWS && it.col < NUM_COLS && it.tidx < len)
        begin
            if (it.sample < grid_minimum)
                grid_minimum = it.sample;
            if (it.row == 0)
            begin
                ref_series[it.tidx] = it.sample;
                if (it.tidx == 0)
                    append_result(make_result(KIND_REF_FIRST, '0, it.sample,
                        it.row, it.col, it.tidx, 1'b0, 1'b1));
                else
                    append_result(make_result(KIND_REF_DELTA,
                        zigzag_of_diff(it.sample, prev_sample), '0,
                        it.row, it.col, it.tidx, 1'b0, 1'b1));
                prev_sample = it.sample;
            end
            else
            begin
                // Constancy always compares against the last in-range sample accepted,
                // whichever cell it came from.
                if (it.tidx == 0)
                begin
                    series_first = it.sample;
                    series_const = 1'b1;
                end
                else if (it.sample != prev_sample)
                    series_const = 1'b0;
                prev_sample = it.sample;
                ends     = (it.tidx == len - 1);
                grid_end = ends && it.row == NUM_ROWS - 1 && it.col == NUM_COLS - 1;
                append_result(make_result(KIND_DIFF,
                    zigzag_of_diff(ref_series[it.tidx], it.sample), '0,
                    it.row, it.col, it.tidx, 1'b0, !ends));
                if (ends)
                    append_result(make_result(KIND_VERDICT, '0, series_first,
                        it.row, it.col, it.tidx, series_const, !grid_end));
                if (grid_end)
                begin
                    append_result(make_result(KIND_MINIMUM, '0, grid_minimum,
                        '0, '0, '0, 1'b0, 1'b1));
                    // Restart the minimum for the next grid.
                    grid_minimum = SAMPLE_MAX;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // Hold a stalled item; otherwise present the next one or idle.
        if (!in_valid || in_taken)
        begin
            if (pending_samples.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid   <= 1'b1;
                sample     <= pending_samples[0].sample;
                grid_row   <= pending_samples[0].row;
                grid_col   <= pending_samples[0].col;
                time_index <= pending_samples[0].tidx;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        sample_item_t accepted;
        result_item_t want;
        in_taken <= (in_valid === 1'b1 && in_stall === 1'b0);
        if (in_valid === 1'b1 && in_stall === 1'b0)
        begin
            accepted = pending_samples.pop_front();
            encode_sample(accepted);
        end
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d row %0d col %0d",
                    kind, out_row, out_col));
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 32'(kind), 32'(want.kind));
                check_field("code", 32'(code), 32'(want.code));
                check_field("raw_value", 32'(raw_value), 32'(want.raw));
                check_field("out_row", 32'(out_row), 32'(want.row));
                check_field("out_col", 32'(out_col), 32'(want.col));
                check_field("out_time", 32'(out_time), 32'(want.tidx));
                check_field("is_constant", 32'(is_constant), 32'(want.cst));
                check_field("last", 32'(last), 32'(want.lst));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one input item. A difference read of a reference entry that was
    // never written is outside the contract: turn such an item into a
    // reference write instead.
    task automatic add_item(logic signed [15:0] s, int row, int col, int t);
        sample_item_t it;
        bit in_series;
        in_series = (row < NUM_ROWS) && (col < NUM_COLS) && (t < gen_len);
        if (in_series && row != 0 && !ref_seen[t])
            row = 0;
        if (in_series && row == 0)
            ref_seen[t] = 1'b1;
        if (in_series)
            live_items++;
        it.sample = s;
        it.row    = row[3:0];
        it.col    = col[3:0];
        it.tidx   = t[9:0];
        pending_samples.insert(pending_samples.size(), it);
    endtask

    // Write the series length while the encoder is idle.
    task automatic write_length(logic [10:0] value);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        series_length <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        length_reg = value;
        gen_len    = (value < 2) ? 2 : ((value > MAX_LEN) ? MAX_LEN : int'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let the
    // pipeline settle in case the last items caused no result.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one complete series for a cell: constant, slowly drifting or random.
    task automatic queue_series(int row, int col);
        int style;
        int t;
        logic signed [15:0] value;
        style = $urandom_range(0, 2);
        value = pick_sample();
        for (t = 0; t < gen_len; t++)
        begin
            if (style == 1)
                value = value + 16'($urandom_range(0, 2)) - 16'd1;
            else if (style == 2)
                value = pick_sample();
            add_item(value, row, col, t);
        end
    endtask

    // Mostly well-formed columns (reference first, then a few rows), with
    // noise and broken series mixed in. Only items the encoder acts on count.
    task automatic queue_random(int target);
        int start;
        int pick;
        int row;
        int col;
        int rows;
        int k;
        start = live_items;
        while (live_items - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                col = ($urandom_range(0, 2) == 0) ? NUM_COLS - 1
                                                  : $urandom_range(0, NUM_COLS - 1);
                queue_series(0, col);
                rows = $urandom_range(1, 3);
                for (k = 0; k < rows; k++)
                begin
                    // Close the grid now and then with the bottom row.
                    row = (k == rows - 1 && $urandom_range(0, 1) == 0)
                        ? NUM_ROWS - 1 : $urandom_range(1, NUM_ROWS - 1);
                    queue_series(row, col);
                end
            end
            else if (pick < 85)
                add_item(pick_sample(), $urandom_range(0, 15), $urandom_range(0, 15),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, gen_len - 1));
            else
            begin
                // Broken series: a few samples at random positions.
                row  = $urandom_range(1, NUM_ROWS - 1);
                col  = $urandom_range(0, NUM_COLS - 1);
                rows = $urandom_range(1, 3);
                for (k = 0; k < rows; k++)
                    add_item(pick_sample(), row, col, $urandom_range(0, gen_len - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("grid_series_reference_delta_encoder_top_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            ref_series[i] = 16'sd0;
            ref_seen[i]   = 1'b0;
        end

        // Hold reset, then release it away from the rising edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Shortest legal series.
        write_length(11'd2);
        add_item(16'sh7FFF, 0, 0, 0);          // reference first value, largest sample
        add_item(16'sh8000, 0, 0, 1);          // reference delta, widest negative step
        add_item(16'sh8000, 1, 0, 0);          // widest positive difference
        add_item(16'sh8000, 1, 0, 1);          // constant series ends
        add_item(16'sd5,    2, 0, 0);
        add_item(16'sd6,    2, 0, 1);          // non-constant series ends
        add_item(16'sd123,  9, 0, 0);          // row outside the grid
        add_item(16'sd7,    0, 9, 0);          // column outside the grid
        add_item(-16'sd1,   15, 15, 1023);     // everything outside
        add_item(16'sd42,   0, 1, 2);          // time past the series end
        add_item(16'sd42,   3, 0, 1023);
        add_item(16'sd100,  3, 0, 1);          // series entered mid-way, no restart
        add_item(16'sd100,  3, 0, 0);
        add_item(16'sd100,  4, 0, 1);          // constancy taken against another cell
        add_item(-16'sd7,   8, 8, 0);
        add_item(-16'sd7,   8, 8, 1);          // grid end: verdict and minimum
        add_item(16'sd300,  8, 8, 0);
        add_item(16'sd200,  8, 8, 1);          // minimum restarted after the grid end
        wait_idle();

        // Length above the maximum clamps to the full series.
        write_length(11'd2047);
        add_item(-16'sd1,    0, 3, 1023);
        add_item(16'sd1234,  5, 4, 1023);
        add_item(16'sh7FFF,  8, 8, 1023);
        wait_idle();

        // Length below the minimum clamps to two.
        write_length(11'd0);
        add_item(16'sd9, 0, 2, 0);
        add_item(16'sd9, 0, 2, 1);
        add_item(16'sd9, 6, 2, 1);
        add_item(16'sd9, 6, 2, 2);
        wait_idle();

        // Random part: several lengths, one stretch with no idling.
        write_length(11'd1);
        queue_random(40);
        wait_idle();

        write_length(11'($urandom_range(3, 6)));
        steady = 1'b1;
        queue_random(40);
        wait_idle();
        steady = 1'b0;

        write_length(11'($urandom_range(2, 8)));
        queue_random(40);
        wait_idle();

        if (error_count == 0)
            $display("grid_series_reference_delta_encoder_top_test passed");
        else
            $display("grid_series_reference_delta_encoder_top_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gsrde_pkg.sv
hdl/grid_series_reference_delta_encoder_top.sv
tb/grid_series_reference_delta_encoder_top_test.sv
